/* src/ddo_pkg.sv */
// Package for the differential drive odometry block: widths, register
// indexes, reset values, request types, sequencer states and the CORDIC table.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package ddo_pkg;

  // Encoder count width and CORDIC length.
  localparam int COUNT_BITS   = 16;
  localparam int CORDIC_STEPS = 24;

  // Arctangent table: ATAN_LEN entries, of which the CORDIC uses one per iteration.
  localparam int ATAN_LEN   = 30;
  localparam int ATAN_IDX_W = $clog2(ATAN_LEN);
  localparam int ITER_W     = $clog2(CORDIC_STEPS);

  // Widths of the internal datapath.
  localparam int ANGLE_W  = 32;
  localparam int POS_W    = 32;
  localparam int DIFF_W   = COUNT_BITS + 2;
  localparam int MAG_W    = COUNT_BITS + 1;
  localparam int CORDIC_W = 33;
  localparam int TMUL_W   = POS_W + 1;
  localparam int MUL_W    = (DIFF_W > 33) ? DIFF_W : 33;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int RND_W    = PROD_W - 16;

  // Inverse CORDIC gain, Q2.30.
  localparam logic signed [CORDIC_W-1:0] CORDIC_INV_GAIN = 33'sd652032874;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 3'd4;

  localparam logic [CFG_DATA_W-1:0] DISTANCE_GAIN_RST = 32'd539722;
  localparam logic [CFG_DATA_W-1:0] HEADING_GAIN_RST  = 32'd753498;

  typedef struct packed {
    logic signed [COUNT_BITS-1:0] left_count_change;
    logic signed [COUNT_BITS-1:0] right_count_change;
  } ddo_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic        [ANGLE_W-1:0] heading_out;
    logic signed [ANGLE_W-1:0] heading_step;
    logic signed [POS_W-1:0]   travel_step;
  } ddo_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD_MUL,
    ST_TRAVEL_MUL,
    ST_TRAVEL_SAT,
    ST_ROTATE,
    ST_X_MUL,
    ST_Y_MUL,
    ST_Y_ACC,
    ST_DONE
  } ddo_state_e;

  // atan(2^-i) in binary angle units (2^32 per turn).
  function automatic logic [ANGLE_W-1:0] atan_angle(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] val;
    case (idx)
      5'd0:    val = 32'd536870912;
      5'd1:    val = 32'd316933406;
      5'd2:    val = 32'd167458907;
      5'd3:    val = 32'd85004756;
      5'd4:    val = 32'd42667331;
      5'd5:    val = 32'd21354465;
      5'd6:    val = 32'd10679838;
      5'd7:    val = 32'd5340245;
      5'd8:    val = 32'd2670163;
      5'd9:    val = 32'd1335087;
      5'd10:   val = 32'd667544;
      5'd11:   val = 32'd333772;
      5'd12:   val = 32'd166886;
      5'd13:   val = 32'd83443;
      5'd14:   val = 32'd41722;
      5'd15:   val = 32'd20861;
      5'd16:   val = 32'd10430;
      5'd17:   val = 32'd5215;
      5'd18:   val = 32'd2608;
      5'd19:   val = 32'd1304;
      5'd20:   val = 32'd652;
      5'd21:   val = 32'd326;
      5'd22:   val = 32'd163;
      5'd23:   val = 32'd81;
      5'd24:   val = 32'd41;
      5'd25:   val = 32'd20;
      5'd26:   val = 32'd10;
      5'd27:   val = 32'd5;
      5'd28:   val = 32'd3;
      5'd29:   val = 32'd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

/* src/diff_drive_odometry.sv */
// Top level of the differential drive odometry block: sequencer, shared
// multiplier, CORDIC rotator, pose and configuration registers.
// Depends on ddo_pkg.
`timescale 1ns / 1ps

// Dead-reckoning pose tracker for a two-wheel robot. Each input request carries
// the left and right encoder count changes of one tick; the right count is
// negated inside the block, so both wheels count forward as positive. The count
// difference times heading_gain is the heading change in binary angle units
// (2^32 per turn, wrapping), and the count sum times distance_gain, rounded half
// away from zero and saturated, is the travel step in signed Q16.16 meters. The
// heading is advanced first; x and y then move by travel times cos and sin of
// the new heading, taken from a CORDIC of CORDIC_STEPS iterations, and wrap
// modulo 2^32. One output request is produced per input request. Each item
// passes through the head multiply, travel multiply, travel saturation, CORDIC
// iterations, x and y multiplies, y accumulate and done before the next can be
// accepted; the wait grows only if out_stall_i still holds the previous result
// when the new one is ready. The single shared 33x33 multiplier sets this pace,
// used four times per item, with the one CORDIC add/shift stage, used once per
// iteration. in_stall_o is high while an item is in progress; a finished result
// sits in its own output register, so a new item can be taken while it waits.
// Writing start_x, start_y or start_heading stores the register and reloads the
// whole pose from the three start registers; gain writes leave the pose alone.
// Configuration must be written only while the block is idle.
module diff_drive_odometry
  import ddo_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input channel.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ddo_in_t               in_req_i,
  // Output channel.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ddo_out_t              out_req_o,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // Sequencer state.
  ddo_state_e state_q, state_d;
  logic [ITER_W-1:0] iter_q, iter_d;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] distance_gain_q, distance_gain_d;
  logic [CFG_DATA_W-1:0] heading_gain_q, heading_gain_d;
  logic [POS_W-1:0]      start_x_q, start_x_d;
  logic [POS_W-1:0]      start_y_q, start_y_d;
  logic [ANGLE_W-1:0]    start_heading_q, start_heading_d;

  // Pose.
  logic [POS_W-1:0]   x_acc_q, x_acc_d;
  logic [POS_W-1:0]   y_acc_q, y_acc_d;
  logic [ANGLE_W-1:0] heading_acc_q, heading_acc_d;

  // Working registers of the current item.
  logic signed [DIFF_W-1:0]   diff_q, diff_d;
  logic [MAG_W-1:0]           mag_q, mag_d;
  logic                       sum_neg_q, sum_neg_d;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic [ANGLE_W-1:0]         hstep_q, hstep_d;
  logic signed [POS_W-1:0]    travel_q, travel_d;
  logic signed [TMUL_W-1:0]   tmul_q, tmul_d;
  logic signed [CORDIC_W-1:0] cx_q, cx_d;
  logic signed [CORDIC_W-1:0] cy_q, cy_d;
  logic signed [CORDIC_W-1:0] cz_q, cz_d;

  // Output register.
  ddo_out_t out_q, out_d;
  logic     out_valid_q, out_valid_d;

  // Shared multiplier operands.
  logic signed [MUL_W-1:0] mul_a, mul_b;

  // Helpers.
  logic                       in_accept;
  logic                       out_free;
  logic signed [DIFF_W-1:0]   diff_w;
  logic signed [DIFF_W-1:0]   sum_w;
  logic [RND_W-1:0]           travel_rnd;
  logic                       flip;
  logic [ANGLE_W-1:0]         rot_angle;
  logic signed [TMUL_W-1:0]   travel_ext;
  logic signed [CORDIC_W-1:0] cx_shift;
  logic signed [CORDIC_W-1:0] cy_shift;
  logic signed [CORDIC_W-1:0] atan_step;
  logic [POS_W-1:0]           pos_step;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // Count difference and sum with the right wheel negated.
  assign diff_w = -DIFF_W'(in_req_i.right_count_change) - DIFF_W'(in_req_i.left_count_change);
  assign sum_w  = DIFF_W'(in_req_i.left_count_change) - DIFF_W'(in_req_i.right_count_change);

  // Travel is |sum| * gain rounded at Q16.16; the product bit below the cut
  // rounds the magnitude half up, which is half away from zero overall.
  assign travel_rnd = RND_W'(prod_q[PROD_W-1:16]) + RND_W'(prod_q[15]);

  // The CORDIC converges over half a turn, so headings in the back half are
  // turned around and the results negated (folded into the travel operand).
  assign flip      = heading_acc_q[ANGLE_W-1] ^ heading_acc_q[ANGLE_W-2];
  assign rot_angle = {heading_acc_q[ANGLE_W-1] ^ flip, heading_acc_q[ANGLE_W-2:0]};
  assign travel_ext = TMUL_W'(travel_d);

  // Shared CORDIC stage.
  assign cx_shift  = cx_q >>> iter_q;
  assign cy_shift  = cy_q >>> iter_q;
  assign atan_step = $signed({1'b0, atan_angle(ATAN_IDX_W'(iter_q))});

  // Position step: product rounded half up at bit 30, low 32 bits kept.
  assign pos_step = prod_q[61:30] + POS_W'(prod_q[29]);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:       if (in_accept) state_d = ST_HEAD_MUL;
      ST_HEAD_MUL:   state_d = ST_TRAVEL_MUL;
      ST_TRAVEL_MUL: state_d = ST_TRAVEL_SAT;
      ST_TRAVEL_SAT: state_d = ST_ROTATE;
      ST_ROTATE:     if (iter_q == ITER_W'(CORDIC_STEPS - 1)) state_d = ST_X_MUL;
      ST_X_MUL:      state_d = ST_Y_MUL;
      ST_Y_MUL:      state_d = ST_Y_ACC;
      ST_Y_ACC:      state_d = ST_DONE;
      ST_DONE:       if (out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_HEAD_MUL: begin
        mul_a = MUL_W'(diff_q);
        mul_b = MUL_W'(heading_gain_q);
      end
      ST_TRAVEL_MUL: begin
        mul_a = MUL_W'(mag_q);
        mul_b = MUL_W'(distance_gain_q);
      end
      ST_X_MUL: begin
        mul_a = MUL_W'(tmul_q);
        mul_b = MUL_W'(cx_q);
      end
      ST_Y_MUL: begin
        mul_a = MUL_W'(tmul_q);
        mul_b = MUL_W'(cy_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Datapath and register updates.
  always_comb begin
    distance_gain_d = distance_gain_q;
    heading_gain_d  = heading_gain_q;
    start_x_d       = start_x_q;
    start_y_d       = start_y_q;
    start_heading_d = start_heading_q;
    x_acc_d         = x_acc_q;
    y_acc_d         = y_acc_q;
    heading_acc_d   = heading_acc_q;
    iter_d          = iter_q;
    diff_d          = diff_q;
    mag_d           = mag_q;
    sum_neg_d       = sum_neg_q;
    prod_d          = mul_a * mul_b;
    hstep_d         = hstep_q;
    travel_d        = travel_q;
    tmul_d          = tmul_q;
    cx_d            = cx_q;
    cy_d            = cy_q;
    cz_d            = cz_q;
    out_d           = out_q;
    out_valid_d     = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          diff_d    = diff_w;
          sum_neg_d = sum_w[DIFF_W-1];
          mag_d     = sum_w[DIFF_W-1] ? MAG_W'(-sum_w) : MAG_W'(sum_w);
        end
      end
      ST_TRAVEL_MUL: begin
        hstep_d       = prod_q[ANGLE_W-1:0];
        heading_acc_d = heading_acc_q + prod_q[ANGLE_W-1:0];
      end
      ST_TRAVEL_SAT: begin
        if (sum_neg_q) begin
          if (travel_rnd > RND_W'(64'h8000_0000)) begin
            travel_d = 32'sh8000_0000;
          end else begin
            travel_d = -$signed(travel_rnd[POS_W-1:0]);
          end
        end else begin
          if (travel_rnd > RND_W'(64'h7FFF_FFFF)) begin
            travel_d = 32'sh7FFF_FFFF;
          end else begin
            travel_d = $signed(travel_rnd[POS_W-1:0]);
          end
        end
        tmul_d = flip ? -travel_ext : travel_ext;
        cx_d   = CORDIC_INV_GAIN;
        cy_d   = '0;
        cz_d   = CORDIC_W'($signed(rot_angle));
        iter_d = '0;
      end
      ST_ROTATE: begin
        if (!cz_q[CORDIC_W-1]) begin
          cx_d = cx_q - cy_shift;
          cy_d = cy_q + cx_shift;
          cz_d = cz_q - atan_step;
        end else begin
          cx_d = cx_q + cy_shift;
          cy_d = cy_q - cx_shift;
          cz_d = cz_q + atan_step;
        end
        iter_d = iter_q + ITER_W'(1);
      end
      ST_Y_MUL: begin
        x_acc_d = x_acc_q + pos_step;
      end
      ST_Y_ACC: begin
        y_acc_d = y_acc_q + pos_step;
      end
      ST_DONE: begin
        if (out_free) begin
          out_d.pos_x        = $signed(x_acc_q);
          out_d.pos_y        = $signed(y_acc_q);
          out_d.heading_out  = heading_acc_q;
          out_d.heading_step = $signed(hstep_q);
          out_d.travel_step  = travel_q;
          out_valid_d        = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Configuration writes must arrive only while idle; the block does not check.
    // A start write reloads the whole pose from the start registers and new value.
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DISTANCE_GAIN: distance_gain_d = cfg_wdata_i;
        REG_HEADING_GAIN:  heading_gain_d  = cfg_wdata_i;
        REG_START_X:       start_x_d       = cfg_wdata_i;
        REG_START_Y:       start_y_d       = cfg_wdata_i;
        REG_START_HEADING: start_heading_d = cfg_wdata_i;
        default: begin
        end
      endcase
      if (cfg_idx_i == REG_START_X || cfg_idx_i == REG_START_Y ||
          cfg_idx_i == REG_START_HEADING) begin
        x_acc_d       = start_x_d;
        y_acc_d       = start_y_d;
        heading_acc_d = start_heading_d;
      end
    end
  end

  // Control, configuration and pose registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      iter_q          <= '0;
      out_valid_q     <= 1'b0;
      distance_gain_q <= DISTANCE_GAIN_RST;
      heading_gain_q  <= HEADING_GAIN_RST;
      start_x_q       <= '0;
      start_y_q       <= '0;
      start_heading_q <= '0;
      x_acc_q         <= '0;
      y_acc_q         <= '0;
      heading_acc_q   <= '0;
    end else begin
      state_q         <= state_d;
      iter_q          <= iter_d;
      out_valid_q     <= out_valid_d;
      distance_gain_q <= distance_gain_d;
      heading_gain_q  <= heading_gain_d;
      start_x_q       <= start_x_d;
      start_y_q       <= start_y_d;
      start_heading_q <= start_heading_d;
      x_acc_q         <= x_acc_d;
      y_acc_q         <= y_acc_d;
      heading_acc_q   <= heading_acc_d;
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk_i) begin
    diff_q    <= diff_d;
    mag_q     <= mag_d;
    sum_neg_q <= sum_neg_d;
    prod_q    <= prod_d;
    hstep_q   <= hstep_d;
    travel_q  <= travel_d;
    tmul_q    <= tmul_d;
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    cz_q      <= cz_d;
    out_q     <= out_d;
  end

endmodule
